// ----- rtl/ssh_pkg.sv -----
package ssh_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int MAX_DEPTH   = 32;
    localparam int DATA_W      = 64;
    localparam int ENTRY_W     = 8;
    localparam int FRAME_W     = 5;
    localparam int DEPTH_W     = 6;
    localparam int USED_W      = 9;

    localparam logic [USED_W-1:0]  ENTRY_LIMIT = USED_W'(MAX_ENTRIES);
    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(MAX_DEPTH);

    typedef enum logic [1:0] {
        CMD_FRAME = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_command;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENT,
        ST_DEP,
        ST_FRMA,
        ST_FRMB,
        ST_NEW,
        ST_CRD,
        ST_CWR,
        ST_META,
        ST_URD,
        ST_UWR,
        ST_RWAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic push;
        logic clear;
        logic start;
        logic rd_load;
        logic e_inc;
        logic k_clr;
        logic k_inc;
        logic drop;
        logic wr_frame;
        logic wr_meta;
        logic calc;
        logic upd;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic e_at_used;
        logic full;
        logic depth_eq;
        logic pdepth_zero;
        logic frm_eq;
        logic k_last;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/ssh_ctrl.sv -----
module ssh_ctrl
    import ssh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_command,
    input  logic       i_last_frame,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_stall
);

    t_state r_state;
    t_state n_state;
    t_command w_command;

    assign w_command = t_command'(i_command);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (w_command)
                        CMD_FRAME: begin
                            o_cmd.push = 1'b1;
                            if (i_last_frame) begin
                                o_cmd.start = 1'b1;
                                n_state = ST_ENT;
                            end
                        end
                        CMD_READ: begin
                            o_cmd.rd_load = 1'b1;
                            n_state = ST_RWAIT;
                        end
                        CMD_CLEAR: o_cmd.clear = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_ENT: begin
                n_state = i_sts.e_at_used ? ST_NEW : ST_DEP;
            end
            ST_DEP: begin
                if (i_sts.depth_eq) begin
                    o_cmd.k_clr = 1'b1;
                    n_state = i_sts.pdepth_zero ? ST_URD : ST_FRMA;
                end else begin
                    o_cmd.e_inc = 1'b1;
                    n_state = ST_ENT;
                end
            end
            ST_FRMA: n_state = ST_FRMB;
            ST_FRMB: begin
                priority if (!i_sts.frm_eq) begin
                    o_cmd.e_inc = 1'b1;
                    n_state = ST_ENT;
                end else if (i_sts.k_last) begin
                    n_state = ST_URD;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = ST_FRMA;
                end
            end
            ST_NEW: begin
                priority if (i_sts.full) begin
                    o_cmd.drop = 1'b1;
                    n_state = ST_OUT;
                end else if (i_sts.pdepth_zero) begin
                    n_state = ST_META;
                end else begin
                    o_cmd.k_clr = 1'b1;
                    n_state = ST_CRD;
                end
            end
            ST_CRD: n_state = ST_CWR;
            ST_CWR: begin
                o_cmd.wr_frame = 1'b1;
                if (i_sts.k_last) begin
                    n_state = ST_META;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = ST_CRD;
                end
            end
            ST_META: begin
                o_cmd.wr_meta = 1'b1;
                n_state = ST_URD;
            end
            ST_URD: begin
                o_cmd.calc = 1'b1;
                n_state = ST_UWR;
            end
            ST_UWR: begin
                o_cmd.upd = 1'b1;
                n_state = ST_OUT;
            end
            ST_RWAIT: n_state = ST_OUT;
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall)
        else $error("input taken while busy");
    a_search_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.start) |=> (r_state == ST_ENT))
        else $error("search did not start");
    a_out_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_out) |=> (r_state == ST_IDLE))
        else $error("result load without return to idle");

endmodule

// ----- rtl/ssh_dp.sv -----
module ssh_dp
    import ssh_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [DATA_W-1:0]   i_frame_addr,
    input  logic                i_empty_stack,
    input  logic [DATA_W-1:0]   i_cpu_ticks,
    input  logic [DATA_W-1:0]   i_mem_peak,
    input  logic [ENTRY_W-1:0]  i_read_entry,
    input  logic [FRAME_W-1:0]  i_read_frame,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_result_kind,
    output logic [ENTRY_W-1:0]  o_entry_index,
    output logic                o_new_entry,
    output logic                o_dropped,
    output logic [DATA_W-1:0]   o_sample_count,
    output logic [DATA_W-1:0]   o_hit_count,
    output logic [DATA_W-1:0]   o_tick_sum,
    output logic [DATA_W-1:0]   o_mem_sum,
    output logic [DEPTH_W-1:0]  o_entry_depth,
    output logic [DATA_W-1:0]   o_frame_value,
    output logic [USED_W-1:0]   o_entries_in_use
);

    logic [DATA_W-1:0]  r_sig_frames [MAX_ENTRIES*MAX_DEPTH];
    logic [DEPTH_W-1:0] r_sig_depth  [MAX_ENTRIES];
    logic [DATA_W-1:0]  r_hits       [MAX_ENTRIES];
    logic [DATA_W-1:0]  r_ticks      [MAX_ENTRIES];
    logic [DATA_W-1:0]  r_mems       [MAX_ENTRIES];
    logic [DATA_W-1:0]  r_pending    [MAX_DEPTH];

    logic [DATA_W-1:0]  r_frame_q, r_pend_q, r_hits_q, r_ticks_q, r_mems_q;
    logic [DEPTH_W-1:0] r_depth_q;

    logic [USED_W-1:0]  r_e;
    logic [FRAME_W-1:0] r_k;
    logic [DEPTH_W-1:0] r_pdepth;
    logic [USED_W-1:0]  r_used;
    logic [DATA_W-1:0]  r_total, r_prev_ticks, r_prev_mem, r_cpu, r_mem;
    logic [DATA_W-1:0]  r_dt, r_dm, r_old_h, r_old_t, r_old_m;
    logic               r_kind, r_created, r_drop;

    logic [ENTRY_W-1:0]         w_ent;
    logic [ENTRY_W+FRAME_W-1:0] w_faddr;
    logic                       w_rvld, w_fvld;

    assign w_ent   = r_e[ENTRY_W-1:0];
    assign w_faddr = {w_ent, r_k};

    // table memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_frame) begin
            r_sig_frames[w_faddr] <= r_pend_q;
        end
        r_frame_q <= r_sig_frames[w_faddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_meta) begin
            r_sig_depth[w_ent] <= r_pdepth;
        end
        r_depth_q <= r_sig_depth[w_ent];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_hits[w_ent]  <= r_old_h + DATA_W'(1);
            r_ticks[w_ent] <= r_old_t + r_dt;
            r_mems[w_ent]  <= r_old_m + r_dm;
        end
        r_hits_q  <= r_hits[w_ent];
        r_ticks_q <= r_ticks[w_ent];
        r_mems_q  <= r_mems[w_ent];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !i_empty_stack && (r_pdepth < DEPTH_LIMIT)) begin
            r_pending[r_pdepth[FRAME_W-1:0]] <= i_frame_addr;
        end
        r_pend_q <= r_pending[r_k];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pdepth     <= '0;
            r_used       <= '0;
            r_total      <= '0;
            r_prev_ticks <= '0;
            r_prev_mem   <= '0;
            r_e          <= '0;
            r_k          <= '0;
            r_kind       <= 1'b0;
            r_created    <= 1'b0;
            r_drop       <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_pdepth     <= '0;
                r_used       <= '0;
                r_total      <= '0;
                r_prev_ticks <= '0;
                r_prev_mem   <= '0;
            end
            if (i_cmd.push && !i_empty_stack && (r_pdepth < DEPTH_LIMIT)) begin
                r_pdepth <= r_pdepth + DEPTH_W'(1);
            end
            if (i_cmd.start) begin
                r_e       <= '0;
                r_k       <= '0;
                r_kind    <= 1'b0;
                r_created <= 1'b0;
                r_drop    <= 1'b0;
            end
            if (i_cmd.rd_load) begin
                r_e    <= {1'b0, i_read_entry};
                r_k    <= i_read_frame;
                r_kind <= 1'b1;
            end
            if (i_cmd.e_inc) begin
                r_e <= r_e + USED_W'(1);
            end
            if (i_cmd.k_clr) begin
                r_k <= '0;
            end
            if (i_cmd.k_inc) begin
                r_k <= r_k + FRAME_W'(1);
            end
            if (i_cmd.drop) begin
                r_drop   <= 1'b1;
                r_pdepth <= '0;
            end
            if (i_cmd.wr_meta) begin
                r_created <= 1'b1;
                r_used    <= r_used + USED_W'(1);
            end
            if (i_cmd.upd) begin
                r_prev_ticks <= r_cpu;
                r_prev_mem   <= r_mem;
                r_total      <= r_total + DATA_W'(1);
                r_pdepth     <= '0;
            end
        end
    end

    // sample readings and deltas
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cpu <= i_cpu_ticks;
            r_mem <= i_mem_peak;
        end
        if (i_cmd.calc) begin
            r_dt    <= (r_prev_ticks != '0) ? (r_cpu - r_prev_ticks) : '0;
            r_dm    <= (r_prev_mem != '0) ? (r_mem - r_prev_mem) : '0;
            r_old_h <= r_created ? '0 : r_hits_q;
            r_old_t <= r_created ? '0 : r_ticks_q;
            r_old_m <= r_created ? '0 : r_mems_q;
        end
    end

    assign o_sts.e_at_used   = (r_e == r_used);
    assign o_sts.full        = (r_used == ENTRY_LIMIT);
    assign o_sts.depth_eq    = (r_depth_q == r_pdepth);
    assign o_sts.pdepth_zero = (r_pdepth == '0);
    assign o_sts.frm_eq      = (r_frame_q == r_pend_q);
    assign o_sts.k_last      = (({1'b0, r_k} + DEPTH_W'(1)) == r_pdepth);
    assign o_sts.out_free    = !o_valid || !i_stall;

    assign w_rvld = (r_e < r_used);
    assign w_fvld = w_rvld && ({1'b0, r_k} < r_depth_q);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_result_kind    <= r_kind;
            o_sample_count   <= r_total;
            o_entries_in_use <= r_used;
            if (r_kind) begin
                o_entry_index <= w_ent;
                o_new_entry   <= 1'b0;
                o_dropped     <= 1'b0;
                o_hit_count   <= w_rvld ? r_hits_q : '0;
                o_tick_sum    <= w_rvld ? r_ticks_q : '0;
                o_mem_sum     <= w_rvld ? r_mems_q : '0;
                o_entry_depth <= w_rvld ? r_depth_q : '0;
                o_frame_value <= w_fvld ? r_frame_q : '0;
            end else begin
                o_entry_index <= r_drop ? '0 : w_ent;
                o_new_entry   <= r_created;
                o_dropped     <= r_drop;
                o_hit_count   <= '0;
                o_tick_sum    <= '0;
                o_mem_sum     <= '0;
                o_entry_depth <= '0;
                o_frame_value <= '0;
            end
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= ENTRY_LIMIT)
        else $error("entry count beyond table size");
    a_pdepth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pdepth <= DEPTH_LIMIT)
        else $error("pending depth beyond bound");
    a_meta_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_meta |=> (r_used == $past(r_used) + USED_W'(1)))
        else $error("new entry not counted");
    a_upd_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd |=> (r_total == $past(r_total) + DATA_W'(1)) && (r_pdepth == '0))
        else $error("sample update incomplete");

endmodule

// ----- rtl/stack_signature_histogram.sv -----
// frame item that is not last: taken without a stall, no result
// sample close, match: search stored entries, compare frames, update counts, load result
// new entry: search, copy frames, write depth, update; drop (table full): search, load result
// read: result after the table read; clear and unknown commands do not stall; next item after load
// reset: control, counts and previous readings cleared; table memories hold old data
// until written and are never read before that
module stack_signature_histogram
    import ssh_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_command,
    input  logic [DATA_W-1:0]   i_frame_addr,
    input  logic                i_last_frame,
    input  logic                i_empty_stack,
    input  logic [DATA_W-1:0]   i_cpu_ticks,
    input  logic [DATA_W-1:0]   i_mem_peak,
    input  logic [ENTRY_W-1:0]  i_read_entry,
    input  logic [FRAME_W-1:0]  i_read_frame,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_result_kind,
    output logic [ENTRY_W-1:0]  o_entry_index,
    output logic                o_new_entry,
    output logic                o_dropped,
    output logic [DATA_W-1:0]   o_sample_count,
    output logic [DATA_W-1:0]   o_hit_count,
    output logic [DATA_W-1:0]   o_tick_sum,
    output logic [DATA_W-1:0]   o_mem_sum,
    output logic [DEPTH_W-1:0]  o_entry_depth,
    output logic [DATA_W-1:0]   o_frame_value,
    output logic [USED_W-1:0]   o_entries_in_use
);

    t_cmd w_cmd;
    t_sts w_sts;

    ssh_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_command    (i_command),
        .i_last_frame (i_last_frame),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd),
        .o_stall      (o_stall)
    );

    ssh_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_frame_addr     (i_frame_addr),
        .i_empty_stack    (i_empty_stack),
        .i_cpu_ticks      (i_cpu_ticks),
        .i_mem_peak       (i_mem_peak),
        .i_read_entry     (i_read_entry),
        .i_read_frame     (i_read_frame),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_kind    (o_result_kind),
        .o_entry_index    (o_entry_index),
        .o_new_entry      (o_new_entry),
        .o_dropped        (o_dropped),
        .o_sample_count   (o_sample_count),
        .o_hit_count      (o_hit_count),
        .o_tick_sum       (o_tick_sum),
        .o_mem_sum        (o_mem_sum),
        .o_entry_depth    (o_entry_depth),
        .o_frame_value    (o_frame_value),
        .o_entries_in_use (o_entries_in_use)
    );

endmodule
